### hw/rtl/aol_pkg.sv
// ----------------------------------------------------------------------------
// aol_pkg
// Shared types and codes for the A* open-list unit: operation and status
// codes, the scan beat that walks the cell chain and the update command.
// ----------------------------------------------------------------------------
package aol_pkg;

    localparam int MAX_COORD_BITS = 16;
    localparam int MAX_IDX_BITS   = 12;
    localparam int COST_BITS      = 16;
    localparam int TOTAL_BITS     = 17;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOWEST = 3'd2;
    localparam logic [2:0] OP_SETVAL = 3'd3;
    localparam logic [2:0] OP_LOOKUP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [COST_BITS-1:0]  COST_MAX  = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic                      valid;
        logic [2:0]                op;
        logic [MAX_COORD_BITS-1:0] key_x;
        logic [MAX_COORD_BITS-1:0] key_y;
        logic                      hit;
        logic [MAX_IDX_BITS-1:0]   hit_idx;
        logic [MAX_IDX_BITS-1:0]   hit_age;
        logic [MAX_COORD_BITS-1:0] hit_x;
        logic [MAX_COORD_BITS-1:0] hit_y;
        logic [COST_BITS-1:0]      hit_cost;
        logic [TOTAL_BITS-1:0]     hit_total;
        logic                      free_ok;
        logic [MAX_IDX_BITS-1:0]   free_idx;
    } scan_t;

    typedef struct packed {
        logic                      valid;
        logic [2:0]                op;
        logic [MAX_IDX_BITS-1:0]   idx;
        logic [MAX_IDX_BITS-1:0]   age;
        logic [MAX_COORD_BITS-1:0] x;
        logic [MAX_COORD_BITS-1:0] y;
        logic [COST_BITS-1:0]      cost;
        logic [TOTAL_BITS-1:0]     total;
    } cmd_t;

endpackage

### hw/rtl/aol_cell.sv
// ----------------------------------------------------------------------------
// aol_cell
// One open-list slot. Holds an entry, folds it into the scan beat passing
// through, and applies update commands addressed to it.
// ----------------------------------------------------------------------------
module aol_cell #(
    parameter int IDX        = 0,
    parameter int COORD_BITS = 10,
    parameter int IDX_BITS   = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  aol_pkg::scan_t scan_in,
    output aol_pkg::scan_t scan_out,
    input  aol_pkg::cmd_t  cmd
);

    logic                           valid_reg;
    logic [COORD_BITS-1:0]          x_reg;
    logic [COORD_BITS-1:0]          y_reg;
    logic [aol_pkg::COST_BITS-1:0]  cost_reg;
    logic [aol_pkg::TOTAL_BITS-1:0] total_reg;
    logic [IDX_BITS-1:0]            age_reg;
    aol_pkg::scan_t                 scan_reg;
    aol_pkg::scan_t                 scan_next;

    logic                             match;
    logic                             take;
    logic [aol_pkg::MAX_IDX_BITS-1:0] age_ext;
    logic                             mine;

    assign age_ext = aol_pkg::MAX_IDX_BITS'(age_reg);
    assign match   = (x_reg == scan_in.key_x[COORD_BITS-1:0]) &&
                     (y_reg == scan_in.key_y[COORD_BITS-1:0]);
    assign mine    = (cmd.idx[IDX_BITS-1:0] == IDX_BITS'(IDX));

    always_comb begin
        scan_next = scan_in;
        take      = 1'b0;
        if (scan_in.op == aol_pkg::OP_LOWEST) begin
            take = !scan_in.hit || (total_reg < scan_in.hit_total) ||
                   ((total_reg == scan_in.hit_total) && (age_ext > scan_in.hit_age));
        end else if (scan_in.op == aol_pkg::OP_REMOVE || scan_in.op == aol_pkg::OP_SETVAL ||
                     scan_in.op == aol_pkg::OP_LOOKUP) begin
            take = match && (!scan_in.hit || (age_ext > scan_in.hit_age));
        end
        if (scan_in.valid && valid_reg && take) begin
            scan_next.hit       = 1'b1;
            scan_next.hit_idx   = aol_pkg::MAX_IDX_BITS'(IDX);
            scan_next.hit_age   = age_ext;
            scan_next.hit_x     = aol_pkg::MAX_COORD_BITS'(x_reg);
            scan_next.hit_y     = aol_pkg::MAX_COORD_BITS'(y_reg);
            scan_next.hit_cost  = cost_reg;
            scan_next.hit_total = total_reg;
        end
        if (scan_in.valid && !valid_reg && !scan_in.free_ok) begin
            scan_next.free_ok  = 1'b1;
            scan_next.free_idx = aol_pkg::MAX_IDX_BITS'(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.valid) begin
            if (mine && cmd.op == aol_pkg::OP_INSERT) begin
                valid_reg <= 1'b1;
            end else if (mine && cmd.op == aol_pkg::OP_REMOVE) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.valid) begin
            if (mine && cmd.op == aol_pkg::OP_INSERT) begin
                x_reg     <= cmd.x[COORD_BITS-1:0];
                y_reg     <= cmd.y[COORD_BITS-1:0];
                cost_reg  <= '0;
                total_reg <= '0;
                age_reg   <= cmd.age[IDX_BITS-1:0];
            end else if (mine && cmd.op == aol_pkg::OP_SETVAL) begin
                cost_reg  <= cmd.cost;
                total_reg <= cmd.total;
            end else if (cmd.op == aol_pkg::OP_REMOVE && valid_reg &&
                         (age_ext > cmd.age)) begin
                // keep ages dense: later entries close the gap
                age_reg <= age_reg - IDX_BITS'(1);
            end
        end
    end

endmodule

### hw/rtl/astar_open_list_unit.sv
// ----------------------------------------------------------------------------
// astar_open_list_unit
// Open-set table for grid A* search built as a chain of slot cells. A scan
// beat walks the chain one cell per cycle, then at most one update command is
// broadcast back to the cells.
//
//   channel | ports            | direction | beat
//   input   | s_valid/s_ready  | in        | mode, position, goal, parent cost
//   result  | m_valid/m_ready  | out       | status, x, y, cost, total
//
// An item's scan beat walks every cell of the chain before the finish step.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is accepted.
// Reset clears all slots at once; no clearing pass.
// A stalled result holds the finish step until the result register frees.
// ----------------------------------------------------------------------------
module astar_open_list_unit #(
    parameter int CAPACITY   = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_mode,
    input  logic [COORD_BITS-1:0]          s_pos_x,
    input  logic [COORD_BITS-1:0]          s_pos_y,
    input  logic [COORD_BITS-1:0]          s_goal_x,
    input  logic [COORD_BITS-1:0]          s_goal_y,
    input  logic                           s_has_parent,
    input  logic [15:0]                    s_parent_cost,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [COORD_BITS-1:0]          m_out_x,
    output logic [COORD_BITS-1:0]          m_out_y,
    output logic [15:0]                    m_out_cost,
    output logic [16:0]                    m_out_total
);

    localparam int IDX_BITS = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int H_BITS   = COORD_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    aol_pkg::scan_t chain [CAPACITY+1];
    aol_pkg::scan_t inj_reg, inj_next;
    aol_pkg::scan_t done_reg, done_next;
    aol_pkg::cmd_t  cmd_reg, cmd_next;

    logic [CNT_BITS-1:0]            count_reg, count_next;
    logic [H_BITS-1:0]              h_reg, h_next;
    logic                           hp_reg, hp_next;
    logic [aol_pkg::COST_BITS-1:0]  pc_reg, pc_next;

    logic                           m_valid_reg, m_valid_next;
    logic [1:0]                     status_reg, status_next;
    logic [COORD_BITS-1:0]          ox_reg, ox_next;
    logic [COORD_BITS-1:0]          oy_reg, oy_next;
    logic [aol_pkg::COST_BITS-1:0]  ocost_reg, ocost_next;
    logic [aol_pkg::TOTAL_BITS-1:0] otot_reg, otot_next;

    logic [COORD_BITS-1:0]          dx, dy;
    logic [aol_pkg::COST_BITS-1:0]  g_val;
    logic [aol_pkg::TOTAL_BITS:0]   f_sum;
    logic [aol_pkg::TOTAL_BITS-1:0] f_val;
    logic                           fin_go;

    assign chain[0] = inj_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            aol_cell #(
                .IDX       (gi),
                .COORD_BITS(COORD_BITS),
                .IDX_BITS  (IDX_BITS)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .scan_in (chain[gi]),
                .scan_out(chain[gi+1]),
                .cmd     (cmd_reg)
            );
        end
    endgenerate

    assign s_ready = (state_reg == ST_IDLE);
    assign fin_go  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    assign dx = (s_pos_x > s_goal_x) ? (s_pos_x - s_goal_x) : (s_goal_x - s_pos_x);
    assign dy = (s_pos_y > s_goal_y) ? (s_pos_y - s_goal_y) : (s_goal_y - s_pos_y);

    assign g_val = !hp_reg ? '0 :
                   (pc_reg == aol_pkg::COST_MAX) ? aol_pkg::COST_MAX :
                   pc_reg + aol_pkg::COST_BITS'(1);
    assign f_sum = (aol_pkg::TOTAL_BITS+1)'(g_val) + (aol_pkg::TOTAL_BITS+1)'(h_reg);
    assign f_val = (f_sum > (aol_pkg::TOTAL_BITS+1)'(aol_pkg::TOTAL_MAX)) ?
                   aol_pkg::TOTAL_MAX : f_sum[aol_pkg::TOTAL_BITS-1:0];

    always_comb begin
        state_next   = state_reg;
        inj_next     = inj_reg;
        inj_next.valid = 1'b0;
        done_next    = done_reg;
        cmd_next     = cmd_reg;
        cmd_next.valid = 1'b0;
        count_next   = count_reg;
        h_next       = h_reg;
        hp_next      = hp_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        ocost_next   = ocost_reg;
        otot_next    = otot_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    inj_next       = '0;
                    inj_next.valid = 1'b1;
                    inj_next.op    = s_mode;
                    inj_next.key_x = aol_pkg::MAX_COORD_BITS'(s_pos_x);
                    inj_next.key_y = aol_pkg::MAX_COORD_BITS'(s_pos_y);
                    h_next         = H_BITS'(dx) + H_BITS'(dy);
                    hp_next        = s_has_parent;
                    pc_next        = s_parent_cost;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (chain[CAPACITY].valid) begin
                    done_next  = chain[CAPACITY];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    m_valid_next = 1'b1;
                    status_next  = aol_pkg::ST_OK;
                    ox_next      = '0;
                    oy_next      = '0;
                    ocost_next   = '0;
                    otot_next    = '0;
                    cmd_next     = '0;
                    cmd_next.op  = done_reg.op;
                    cmd_next.x   = done_reg.key_x;
                    cmd_next.y   = done_reg.key_y;
                    case (done_reg.op)
                        aol_pkg::OP_INSERT: begin
                            if (!done_reg.free_ok) begin
                                status_next = aol_pkg::ST_FULL;
                            end else begin
                                cmd_next.valid = 1'b1;
                                cmd_next.idx   = done_reg.free_idx;
                                cmd_next.age   = aol_pkg::MAX_IDX_BITS'(count_reg);
                                count_next     = count_reg + CNT_BITS'(1);
                            end
                        end
                        aol_pkg::OP_REMOVE: begin
                            if (!done_reg.hit) begin
                                status_next = aol_pkg::ST_NOTFOUND;
                            end else begin
                                cmd_next.valid = 1'b1;
                                cmd_next.idx   = done_reg.hit_idx;
                                cmd_next.age   = done_reg.hit_age;
                                count_next     = count_reg - CNT_BITS'(1);
                            end
                        end
                        aol_pkg::OP_LOWEST: begin
                            if (!done_reg.hit) begin
                                status_next = aol_pkg::ST_EMPTY;
                            end else begin
                                ox_next    = done_reg.hit_x[COORD_BITS-1:0];
                                oy_next    = done_reg.hit_y[COORD_BITS-1:0];
                                ocost_next = done_reg.hit_cost;
                                otot_next  = done_reg.hit_total;
                            end
                        end
                        aol_pkg::OP_SETVAL: begin
                            if (!done_reg.hit) begin
                                status_next = aol_pkg::ST_NOTFOUND;
                            end else begin
                                cmd_next.valid = 1'b1;
                                cmd_next.idx   = done_reg.hit_idx;
                                cmd_next.cost  = g_val;
                                cmd_next.total = f_val;
                                ocost_next     = g_val;
                                otot_next      = f_val;
                            end
                        end
                        aol_pkg::OP_LOOKUP: begin
                            if (!done_reg.hit) begin
                                status_next = aol_pkg::ST_NOTFOUND;
                            end else begin
                                ocost_next = done_reg.hit_cost;
                                otot_next  = done_reg.hit_total;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inj_reg     <= '0;
            cmd_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inj_reg     <= inj_next;
            cmd_reg     <= cmd_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        done_reg   <= done_next;
        h_reg      <= h_next;
        hp_reg     <= hp_next;
        pc_reg     <= pc_next;
        status_reg <= status_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ocost_reg  <= ocost_next;
        otot_reg   <= otot_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_x     = ox_reg;
    assign m_out_y     = oy_reg;
    assign m_out_cost  = ocost_reg;
    assign m_out_total = otot_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[CAPACITY].valid |-> state_reg == ST_SCAN)
        else $error("scan beat left chain outside scan");

    a_cmd_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg.valid |=> !cmd_reg.valid)
        else $error("update command held more than one cycle");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_go && done_reg.op == aol_pkg::OP_INSERT && !done_reg.free_ok)
        |-> count_reg == CNT_BITS'(CAPACITY))
        else $error("full reported with free slots");
`endif

endmodule

### verif/astar_open_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_open_list_checker
// Watches both channels of the open-list unit. Every accepted input beat is
// applied to a local copy of the open set, and the predicted result is
// queued. Every accepted result beat is compared field by field with the
// oldest queued prediction.
// ----------------------------------------------------------------------------
module astar_open_list_checker #(
    parameter int CAPACITY   = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [COORD_BITS-1:0] s_goal_x,
    input  logic [COORD_BITS-1:0] s_goal_y,
    input  logic                  s_has_parent,
    input  logic [15:0]           s_parent_cost,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_status,
    input  logic [COORD_BITS-1:0] m_out_x,
    input  logic [COORD_BITS-1:0] m_out_y,
    input  logic [15:0]           m_out_cost,
    input  logic [16:0]           m_out_total,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [1:0]            status;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [15:0]           cost;
        logic [16:0]           total;
    } answer_t;

    logic                  slot_used  [CAPACITY];
    logic [COORD_BITS-1:0] slot_x     [CAPACITY];
    logic [COORD_BITS-1:0] slot_y     [CAPACITY];
    logic [15:0]           slot_cost  [CAPACITY];
    logic [16:0]           slot_total [CAPACITY];
    logic [15:0]           slot_age   [CAPACITY];
    logic [15:0]           age_next;

    answer_t answer_q[$];
    int      beats_seen;

    function automatic int newest_match(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
        int hit;
        hit = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && slot_x[i] == x && slot_y[i] == y) begin
                if (hit < 0 || slot_age[i] > slot_age[hit]) hit = i;
            end
        end
        return hit;
    endfunction

    task automatic compact_ages();
        logic [15:0] rank [CAPACITY];
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            rank[i] = '0;
            if (slot_used[i]) begin
                n++;
                for (int j = 0; j < CAPACITY; j++) begin
                    if (slot_used[j] && slot_age[j] < slot_age[i]) rank[i]++;
                end
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i]) slot_age[i] = rank[i];
        end
        age_next = n[15:0];
    endtask

    task automatic apply_operation(output answer_t r);
        int    k;
        int    g;
        int    h;
        int    f;
        r = '0;
        case (s_mode)
            aol_pkg::OP_INSERT: begin
                k = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!slot_used[i] && k < 0) k = i;
                end
                if (k < 0) begin
                    r.status = aol_pkg::ST_FULL;
                end else begin
                    if (age_next == 16'hFFFF) compact_ages();
                    slot_used[k]  = 1'b1;
                    slot_x[k]     = s_pos_x;
                    slot_y[k]     = s_pos_y;
                    slot_cost[k]  = '0;
                    slot_total[k] = '0;
                    slot_age[k]   = age_next;
                    age_next      = age_next + 16'd1;
                    r.status      = aol_pkg::ST_OK;
                end
            end
            aol_pkg::OP_REMOVE: begin
                k = newest_match(s_pos_x, s_pos_y);
                if (k < 0) r.status = aol_pkg::ST_NOTFOUND;
                else slot_used[k] = 1'b0;
            end
            aol_pkg::OP_LOWEST: begin
                k = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (slot_used[i]) begin
                        if (k < 0 || slot_total[i] < slot_total[k] ||
                            (slot_total[i] == slot_total[k] && slot_age[i] > slot_age[k]))
                            k = i;
                    end
                end
                if (k < 0) begin
                    r.status = aol_pkg::ST_EMPTY;
                end else begin
                    r.x     = slot_x[k];
                    r.y     = slot_y[k];
                    r.cost  = slot_cost[k];
                    r.total = slot_total[k];
                end
            end
            aol_pkg::OP_SETVAL: begin
                k = newest_match(s_pos_x, s_pos_y);
                if (k < 0) begin
                    r.status = aol_pkg::ST_NOTFOUND;
                end else begin
                    g = !s_has_parent ? 0 :
                        (s_parent_cost == 16'hFFFF) ? 65535 : int'(s_parent_cost) + 1;
                    h = ((slot_x[k] > s_goal_x) ? slot_x[k] - s_goal_x : s_goal_x - slot_x[k])
                      + ((slot_y[k] > s_goal_y) ? slot_y[k] - s_goal_y : s_goal_y - slot_y[k]);
                    f = g + h;
                    if (f > 131071) f = 131071;
                    slot_cost[k]  = g[15:0];
                    slot_total[k] = f[16:0];
                    r.cost        = g[15:0];
                    r.total       = f[16:0];
                end
            end
            aol_pkg::OP_LOOKUP: begin
                k = newest_match(s_pos_x, s_pos_y);
                if (k < 0) begin
                    r.status = aol_pkg::ST_NOTFOUND;
                end else begin
                    r.cost  = slot_cost[k];
                    r.total = slot_total[k];
                end
            end
            default: ;
        endcase
    endtask

    assign pending = answer_q.size();

    initial begin
        fail_count = 0;
        beats_seen = 0;
        age_next   = '0;
        for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
    end

    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_status, m_out_x, m_out_y, m_out_cost, m_out_total};
                beats_seen++;
                if (answer_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result beat %0d: %p", beats_seen, got);
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: beat %0d expected %p got %p",
                                     beats_seen, want, got);
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_operation(want);
                answer_q.push_back(want);
            end
        end
    end

endmodule

### verif/tb_astar_open_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_astar_open_list_unit
// Drives the open-list unit with directed beats covering empty, duplicate,
// saturating and unused-mode cases, then with random operation mixes over a
// small coordinate pool, a fill to full and a drain. The checker instance
// predicts and compares; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_astar_open_list_unit;

    localparam int CAPACITY   = 256;
    localparam int COORD_BITS = 10;
    localparam int QUIET_MAX  = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [2:0]            s_mode;
    logic [COORD_BITS-1:0] s_pos_x;
    logic [COORD_BITS-1:0] s_pos_y;
    logic [COORD_BITS-1:0] s_goal_x;
    logic [COORD_BITS-1:0] s_goal_y;
    logic                  s_has_parent;
    logic [15:0]           s_parent_cost;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [COORD_BITS-1:0] m_out_x;
    logic [COORD_BITS-1:0] m_out_y;
    logic [15:0]           m_out_cost;
    logic [16:0]           m_out_total;

    int fail_count;
    int pending;
    int sent;
    int quiet;
    bit idle_on;

    astar_open_list_unit #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) DUT (.*);

    astar_open_list_checker #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                stall   = $urandom_range(0, 2);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("ERROR: no handshake for %0d cycles", QUIET_MAX);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input logic [2:0] mode, input logic [COORD_BITS-1:0] px,
                             input logic [COORD_BITS-1:0] py,
                             input logic [COORD_BITS-1:0] gx,
                             input logic [COORD_BITS-1:0] gy,
                             input logic hp, input logic [15:0] pc);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_mode        = mode;
        s_pos_x       = px;
        s_pos_y       = py;
        s_goal_x      = gx;
        s_goal_y      = gy;
        s_has_parent  = hp;
        s_parent_cost = pc;
        #1;
        while (!s_ready) begin
            @(negedge aclk);
            #1;
        end
        @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    task automatic random_beat(input bit insert_heavy);
        logic [2:0]            mode;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [15:0]           pc;
        int                    pick;
        pick = $urandom_range(0, 99);
        if (pick < (insert_heavy ? 40 : 25)) mode = aol_pkg::OP_INSERT;
        else if (pick < 45) mode = aol_pkg::OP_REMOVE;
        else if (pick < 63) mode = aol_pkg::OP_LOWEST;
        else if (pick < 83) mode = aol_pkg::OP_SETVAL;
        else if (pick < 97) mode = aol_pkg::OP_LOOKUP;
        else mode = 3'($urandom_range(5, 7));
        px = COORD_BITS'($urandom_range(0, 7));
        py = COORD_BITS'($urandom_range(0, 7));
        if (mode != aol_pkg::OP_INSERT && $urandom_range(0, 5) == 0) begin
            px = COORD_BITS'($urandom);
            py = COORD_BITS'($urandom);
        end
        case ($urandom_range(0, 3))
            0: pc = 16'hFFFF;
            1: pc = 16'hFFFE;
            default: pc = 16'($urandom);
        endcase
        send_beat(mode, px, py, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  1'($urandom), pc);
    endtask

    initial begin
        s_valid       = 1'b0;
        s_mode        = aol_pkg::OP_INSERT;
        s_pos_x       = '0;
        s_pos_y       = '0;
        s_goal_x      = '0;
        s_goal_y      = '0;
        s_has_parent  = 1'b0;
        s_parent_cost = '0;
        aresetn       = 1'b0;
        idle_on       = 1'b1;
        sent          = 0;
        quiet         = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed
        send_beat(aol_pkg::OP_LOWEST, 0, 0, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_REMOVE, 3, 3, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_LOOKUP, 3, 3, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_SETVAL, 3, 3, 0, 0, 1, 5);
        send_beat(aol_pkg::OP_INSERT, 0, 0, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_INSERT, 1023, 1023, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_LOWEST, 0, 0, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_SETVAL, 1023, 1023, 0, 0, 1, 16'hFFFF);
        send_beat(aol_pkg::OP_SETVAL, 0, 0, 1023, 1023, 1, 16'hFFFE);
        send_beat(aol_pkg::OP_LOOKUP, 1023, 1023, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_SETVAL, 0, 0, 0, 0, 0, 16'hFFFF);
        send_beat(aol_pkg::OP_LOWEST, 0, 0, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_INSERT, 5, 5, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_INSERT, 5, 5, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_SETVAL, 5, 5, 9, 5, 1, 2);
        send_beat(aol_pkg::OP_LOWEST, 0, 0, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_REMOVE, 5, 5, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_LOOKUP, 5, 5, 0, 0, 0, 0);
        send_beat(3'd5, 1023, 1023, 1023, 1023, 1, 16'hFFFF);
        send_beat(3'd6, 0, 0, 0, 0, 0, 0);
        send_beat(3'd7, 1, 1, 1, 1, 1, 1);
        send_beat(aol_pkg::OP_REMOVE, 5, 5, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_REMOVE, 1023, 1023, 0, 0, 0, 0);
        send_beat(aol_pkg::OP_LOWEST, 0, 0, 0, 0, 0, 0);

        repeat (700) random_beat(1'b1);
        // fill past the point where the table reports full
        for (int i = 0; i < CAPACITY + 8; i++)
            send_beat(aol_pkg::OP_INSERT, COORD_BITS'(i % 8), COORD_BITS'((i / 8) % 8),
                      0, 0, 0, 0);
        repeat (150) random_beat(1'b1);
        // drain the pool
        for (int i = 0; i < 512; i++)
            send_beat(aol_pkg::OP_REMOVE, COORD_BITS'(i % 8), COORD_BITS'((i / 8) % 8),
                      0, 0, 0, 0);
        send_beat(aol_pkg::OP_LOWEST, 0, 0, 0, 0, 0, 0);
        idle_on = 1'b0;
        repeat (150) random_beat(1'b1);
        s_valid = 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (3 * (CAPACITY + 3)) @(posedge aclk);

        $display("Sent %0d beats: every operation, empty and full table, duplicates,", sent);
        $display("saturating costs, unused modes, with random idling on both channels.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/aol_pkg.sv
hw/rtl/aol_cell.sv
hw/rtl/astar_open_list_unit.sv
verif/astar_open_list_checker.sv
verif/tb_astar_open_list_unit.sv
